// ===== hdl/hme_pkg.sv =====
// Shared types and constants of the binary min-heap engine.
// No dependencies; imported by binary_min_heap_engine.
package hme_pkg;

   // Item opcodes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // Value returned by extract or peek on an empty heap
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_ROOT     = 6'b000010,
      S_BLD_RD   = 6'b000100,
      S_BLD_GET  = 6'b001000,
      S_SIFT_RD  = 6'b010000,
      S_SIFT_CMP = 6'b100000
   } state_type;

endpackage

// ===== hdl/binary_min_heap_engine.sv =====
// Binary min-heap engine: sequencer, heap store memory and result registers.
// Depends on hme_pkg.

// The heap sits in one DEPTH x 32 memory with two registered read ports and
// one write port; element count resets to zero and the store needs no
// clearing pass. An item is taken when start is high and busy is low; its
// single result appears on the rsp_ ports for one cycle with rsp_valid high,
// and the receiver cannot stall it. A load without last is written in the
// accepting cycle if the heap has room and leaves busy low, so loads stream
// one per cycle. Peek reads the root in the ROOT state; the empty-heap and
// unused-opcode cases answer straight from idle. Extract reads the root and
// the last element, then, if elements remain, sifts down one heap level per
// pass (read both children, then compare and write back). A load flagged last
// runs the bottom-up build, which fetches each parent and sifts it down.
// The count output is the element count masked to 11 bits.
module binary_min_heap_engine
   import hme_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic [10:0]        rsp_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = AW + 2;

   // Heap store and its registered read data
   logic signed [31:0] heap_mem [DEPTH];
   logic signed [31:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]      rd_addr_a, rd_addr_b;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   // Control and datapath registers
   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      bld_ff, bld_in;
   logic [AW-1:0]      node_ff, node_in;
   logic signed [31:0] cur_ff, cur_in;
   logic [1:0]         op_ff, op_in;
   logic               build_ff, build_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic [CW-1:0]      count_dec;
   logic [CW-1:0]      bld_dec;
   logic               has_room;
   logic [XW-1:0]      left_idx, right_idx, count_x;
   logic               left_ok, right_ok;
   logic               take_left, take_right;
   logic signed [31:0] best_val;
   logic [CW+10:0]     count_wide;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign count_dec = count_ff - CW'(1);
   assign bld_dec   = bld_ff - CW'(1);
   assign has_room  = (count_ff < CW'(DEPTH));

   // Child indexes of the current node and their range checks
   assign left_idx  = {1'b0, node_ff, 1'b1};
   assign right_idx = left_idx + XW'(1);
   assign count_x   = XW'(count_ff);
   assign left_ok   = (left_idx < count_x);
   assign right_ok  = (right_idx < count_x);

   // Pick the smallest of node value, left child and right child
   always_comb begin
      take_left  = left_ok && (rd_a_ff < cur_ff);
      best_val   = take_left ? rd_a_ff : cur_ff;
      take_right = right_ok && (rd_b_ff < best_val);
      if (take_right) begin
         best_val = rd_b_ff;
      end
   end

   // Memory read address selection
   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = count_dec[AW-1:0];
      unique case (state_ff)
         S_BLD_RD: begin
            rd_addr_a = bld_dec[AW-1:0];
         end
         S_SIFT_RD: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Memory write selection; the reads whose data is used fall in other states
   // than the writes, so no used read meets a write to its entry
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = cur_ff;
      if (accept && (req_opcode == OP_LOAD) && has_room) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = req_value;
      end else if (state_ff == S_SIFT_CMP) begin
         wr_en   = 1'b1;
         wr_data = best_val;
      end
   end

   // Heap store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   // Sequencer next-state logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      bld_in        = bld_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      op_in         = op_ff;
      build_in      = build_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               if (req_opcode == OP_LOAD) begin
                  rsp_value_in  = '0;
                  rsp_status_in = has_room ? ST_OK : ST_OVERFLOW;
                  if (has_room) begin
                     count_in = count_ff + CW'(1);
                  end
                  if (req_last) begin
                     build_in = 1'b1;
                     bld_in   = count_in >> 1;
                     state_in = S_BLD_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if ((req_opcode == OP_EXTRACT) || (req_opcode == OP_PEEK)) begin
                  if (count_ff == '0) begin
                     rsp_value_in  = INT_MAX;
                     rsp_status_in = ST_EMPTY;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = S_ROOT;
                  end
               end else begin
                  rsp_value_in  = '0;
                  rsp_status_in = ST_OK;
                  rsp_valid_in  = 1'b1;
               end
            end
         end
         S_ROOT: begin
            // Root in port A, last element in port B
            rsp_value_in  = rd_a_ff;
            rsp_status_in = ST_OK;
            if (op_ff == OP_EXTRACT) begin
               count_in = count_dec;
               if (count_ff > CW'(1)) begin
                  cur_in   = rd_b_ff;
                  node_in  = '0;
                  build_in = 1'b0;
                  state_in = S_SIFT_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_BLD_RD: begin
            // Advance to the next parent, or finish the build
            if (bld_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               bld_in   = bld_dec;
               node_in  = bld_dec[AW-1:0];
               state_in = S_BLD_GET;
            end
         end
         S_BLD_GET: begin
            cur_in   = rd_a_ff;
            state_in = S_SIFT_RD;
         end
         S_SIFT_RD: begin
            state_in = S_SIFT_CMP;
         end
         S_SIFT_CMP: begin
            // Move the smaller child up and descend, or drop the value here
            if (take_right) begin
               node_in  = right_idx[AW-1:0];
               state_in = S_SIFT_RD;
            end else if (take_left) begin
               node_in  = left_idx[AW-1:0];
               state_in = S_SIFT_RD;
            end else if (build_ff) begin
               state_in = S_BLD_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bld_ff        <= bld_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      op_ff         <= op_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Drive result ports
   assign count_wide       = {11'b0, count_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = count_wide[10:0];

   // Element count never exceeds the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above depth");

   // Sift-down only works on nodes inside the heap
   a_sift_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIFT_CMP) |-> (CW'(node_ff) < count_ff))
      else $error("sift node outside heap");

   // Empty status always comes with the maximum value and a zero count
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> ((rsp_result_value == INT_MAX)
         && (count_ff == '0)))
      else $error("empty result inconsistent");

   // An unused opcode answers next cycle and leaves the count alone
   a_unused_op: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode != OP_LOAD) && (req_opcode != OP_EXTRACT)
         && (req_opcode != OP_PEEK))
      |=> (rsp_valid && (rsp_status == ST_OK) && $stable(count_ff)))
      else $error("unused opcode mishandled");

endmodule
